// File: hw/rtl/scdf_pkg.sv
// Shared constants and types of the serial CAN frame deframer.
`default_nettype none

package scdf_pkg;

  // Frame header: identifier low, identifier high, remote flag, length.
  localparam int unsigned HdrBytes      = 4;
  localparam int unsigned LenPos        = 3;
  localparam int unsigned MaxPayloadDef = 8;
  localparam int unsigned MaxPayloadLim = 8;
  // Wide enough to hold HdrBytes + MaxPayloadLim.
  localparam int unsigned CountW        = 4;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MsgIdW   = 16;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PayloadW = ByteW * MaxPayloadLim;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } in_stage_t;

  typedef struct packed {
    logic [MsgIdW-1:0]   msg_id;
    logic [ByteW-1:0]    remote_flag;
    logic [LenW-1:0]     payload_len;
    logic [PayloadW-1:0] payload;
  } msg_t;

endpackage

`default_nettype wire

// File: hw/rtl/scdf_if.sv
// Request channels of the serial CAN frame deframer: received bytes and messages.
`default_nettype none

interface scdf_in_if;
  import scdf_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scdf_out_if;
  import scdf_pkg::*;
  logic                valid;
  logic                ready;
  logic [MsgIdW-1:0]   msg_id;
  logic [ByteW-1:0]    remote_flag;
  logic [LenW-1:0]     payload_len;
  logic [PayloadW-1:0] payload;

  modport source (output valid, output msg_id, output remote_flag, output payload_len,
                  output payload, input ready);
  modport sink   (input valid, input msg_id, input remote_flag, input payload_len,
                  input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/scdf_in_reg.sv
// Input register of the deframer: holds one received byte until it is assembled.
`default_nettype none

module scdf_in_reg
  import scdf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             take_i,
  output in_stage_t             stage_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  // The register may refill in the same cycle as its content is taken.
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.rx_byte = byte_q;

endmodule

`default_nettype wire

// File: hw/rtl/scdf_frame_asm.sv
// Frame assembler: byte counter, frame store and the registered message output.
`default_nettype none

module scdf_frame_asm
  import scdf_pkg::*;
#(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_stage_t stage_i,
  output logic           take_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output msg_t           msg_o
);

  localparam int unsigned StoreDepth = HdrBytes + MaxPayload;

  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  store_q  [StoreDepth];
  logic [ByteW-1:0]  store_nx [StoreDepth];
  logic              out_valid_q;
  msg_t              msg_q, msg_d;

  logic [CountW-1:0] pos, pos_inc, frame_end;
  logic [ByteW-1:0]  len;
  logic              hdr_done, too_long, complete;

  assign take_o = stage_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    // A counter outside the store starts a fresh frame.
    pos = (count_q >= CountW'(StoreDepth)) ? '0 : count_q;
    for (int k = 0; k < StoreDepth; k++) begin
      store_nx[k] = (pos == CountW'(k)) ? stage_i.rx_byte : store_q[k];
    end
    pos_inc   = pos + CountW'(1);
    len       = store_nx[LenPos];
    hdr_done  = pos_inc >= CountW'(HdrBytes);
    too_long  = len > ByteW'(MaxPayload);
    frame_end = CountW'(HdrBytes) + len[CountW-1:0];
    complete  = hdr_done && !too_long && (pos_inc == frame_end);

    count_d = (hdr_done && (too_long || complete)) ? '0 : pos_inc;

    msg_d.msg_id      = {store_nx[1], store_nx[0]};
    msg_d.remote_flag = store_nx[2];
    msg_d.payload_len = len[LenW-1:0];
    msg_d.payload     = '0;
    for (int i = 0; i < MaxPayload; i++) begin
      if (ByteW'(i) < len) begin
        msg_d.payload[ByteW*i +: ByteW] = store_nx[HdrBytes + i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      count_q     <= count_d;
      out_valid_q <= complete;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      for (int k = 0; k < StoreDepth; k++) begin
        store_q[k] <= store_nx[k];
      end
      if (complete) begin
        msg_q <= msg_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign msg_o       = msg_q;

endmodule

`default_nettype wire

// File: hw/rtl/serial_can_frame_deframer_unit.sv
// Top level of the serial CAN frame deframer.
`default_nettype none

// Channel   Direction  Request carries
// in_ch     sink       rx_byte: one byte from the serial receiver
// out_ch    source     msg_id, remote_flag, payload_len, payload: one whole message
//
// A byte is held in the input register until the assembler takes it, and the
// message register is loaded as the last byte of a frame is taken. A new byte
// is accepted every cycle while no finished message is stalled, set by the
// single counter update in the assembler. Reset clears the byte counter and
// both valid flags; the frame store keeps no reset value. A stalled message
// holds the assembler, and the input register then fills and drops ready.

module serial_can_frame_deframer_unit
  import scdf_pkg::*;
#(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  scdf_in_if.sink   in_ch,
  scdf_out_if.source out_ch
);

  in_stage_t stage;
  logic      take;
  msg_t      msg;

  // The input register parts the serial side from the assembler, so that a
  // byte can be taken while a finished message still waits downstream.
  scdf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_byte_i  (in_ch.rx_byte),
    .take_i     (take),
    .stage_o    (stage)
  );

  // The assembler writes each byte at the counter position, checks the length
  // once the header is complete, silently drops an over-long frame, and loads
  // the message register when the last byte of the frame is in.
  scdf_frame_asm #(
    .MaxPayload (MaxPayload)
  ) u_frame_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .take_o      (take),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .msg_o       (msg)
  );

  assign out_ch.msg_id      = msg.msg_id;
  assign out_ch.remote_flag = msg.remote_flag;
  assign out_ch.payload_len = msg.payload_len;
  assign out_ch.payload     = msg.payload;

endmodule

`default_nettype wire
